[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the curve evaluator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/cr_eval_pkg.sv]
// ----------------------------------------------------------------------------
// cr_eval_pkg
// Types, constants and rounding helpers for the closed-curve evaluator.
// ----------------------------------------------------------------------------
package cr_eval_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int COORD_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int SLOT_W      = 6;
   localparam int CNT_W       = 7;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = ACC_W + FRAC_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam logic [CNT_W-1:0] CNT_RESET = 7'd4;

   localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) << (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0]  SAT_HI = {{(ACC_W-COORD_W+1){1'b0}},
                                                  {(COORD_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  SAT_LO = {{(ACC_W-COORD_W+1){1'b1}},
                                                  {(COORD_W-1){1'b0}}};

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [SLOT_W-1:0]             slot;
      logic [2:0][COORD_W-1:0]       coord;
      logic [FRAC_W-1:0]             frac;
   } cmd_type;

   // Round to nearest with ties toward plus infinity, dropping 16 bits.
   function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] t;
      t = v + HALF16;
      return t[ACC_W+FRAC_W-1:FRAC_W];
   endfunction

   // Drop one bit with the same rounding, then clamp to the 32-bit range.
   function automatic logic [COORD_W-1:0] rnd1_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      logic signed [ACC_W-1:0] s;
      t = v + ACC_W'(1);
      s = t >>> 1;
      if (s > SAT_HI) begin
         return SAT_HI[COORD_W-1:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[COORD_W-1:0];
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

[src/cr_eval_ram.sv]
// ----------------------------------------------------------------------------
// cr_eval_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cr_eval_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cr_eval_front.sv]
// ----------------------------------------------------------------------------
// cr_eval_front
// Accepts items, works out segment, fraction and the four cyclic point
// indices of an evaluate, and queues the decoded command for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cr_eval_front
   import cr_eval_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [CNT_W-1:0]                      num_points,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cmd_type                               req_cmd,
   output logic                                  q_valid,
   input  logic                                  q_pop,
   output cmd_type                               q_cmd,
   output logic [3:0][$clog2(MAX_POINTS)-1:0]    q_idx
);

   localparam int IW = $clog2(MAX_POINTS);

   cmd_type               cmd_ff [QUEUE_DEPTH];
   logic [3:0][IW-1:0]    idx_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   logic                  push;
   logic                  eval_push, idx_ok;
   logic [CNT_W-1:0]      cnt_eff, last;
   logic [FRAC_W+CNT_W-1:0] prod;
   logic [CNT_W-1:0]      seg, i0, i2, i3;
   logic [3:0][IW-1:0]    idx_new;
   cmd_type               cmd_new;

   // The parameter times the clamped count gives segment and local fraction.
   always_comb begin
      if (num_points == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (32'(num_points) > MAX_POINTS) begin
         cnt_eff = CNT_W'(MAX_POINTS);
      end else begin
         cnt_eff = num_points;
      end
      last = cnt_eff - CNT_W'(1);
      prod = req_cmd.frac * cnt_eff;
      seg  = prod[FRAC_W+CNT_W-1:FRAC_W];
      i0   = (seg == '0) ? last : seg - CNT_W'(1);
      i2   = (seg == last) ? '0 : seg + CNT_W'(1);
      i3   = (i2 == last) ? '0 : i2 + CNT_W'(1);
      idx_new[0] = IW'(i0);
      idx_new[1] = IW'(seg);
      idx_new[2] = IW'(i2);
      idx_new[3] = IW'(i3);
      cmd_new      = req_cmd;
      cmd_new.frac = prod[FRAC_W-1:0];
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = cmd_ff[rd_ptr_ff];
   assign q_idx     = idx_ff[rd_ptr_ff];

   assign eval_push = push && (req_cmd.op == OP_EVAL);
   assign idx_ok    = (i3 < cnt_eff) && (seg < cnt_eff);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= cmd_new;
         idx_ff[wr_ptr_ff] <= idx_new;
      end
   end

   `ASSERT_IMPLIES(a_q_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH), "bad fill")
   `ASSERT_IMPLIES(a_idx_range, clock, reset, eval_push, idx_ok, "point index beyond count")

endmodule

[src/cr_eval_back.sv]
// ----------------------------------------------------------------------------
// cr_eval_back
// Holds the point table, reads four points per evaluate and runs the Horner
// pipeline for position and derivative of all three axes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cr_eval_back
   import cr_eval_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   output logic                                  q_pop,
   input  cmd_type                               q_cmd,
   input  logic [3:0][$clog2(MAX_POINTS)-1:0]    q_idx,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0][COORD_W-1:0]               rsp_pos,
   output logic [2:0][COORD_W-1:0]               rsp_deriv
);

   localparam int IW = $clog2(MAX_POINTS);

   logic adv, load_we;
   logic [3:0][3*COORD_W-1:0] rd_data;

   logic v_rd_ff, v_a_ff, v_b_ff, v_c_ff, v_d_ff, rsp_valid_ff;
   logic [FRAC_W-1:0] f_rd_ff, f_a_ff, f_b_ff, f_c_ff;

   logic signed [ACC_W-1:0] c0_ff [3], c0_in [3];
   logic signed [ACC_W-1:0] c0x3_ff [3], c0x3_in [3];
   logic signed [ACC_W-1:0] c1_ff [3], c1_in [3];
   logic signed [ACC_W-1:0] c1x2_ff [3], c1x2_in [3];
   logic signed [ACC_W-1:0] c2a_ff [3], c2a_in [3];
   logic signed [ACC_W-1:0] p1a_ff [3], p1a_in [3];
   logic signed [PROD_W-1:0] m1_ff [3], m1_in [3];
   logic signed [PROD_W-1:0] mg1_ff [3], mg1_in [3];
   logic signed [ACC_W-1:0] c1b_ff [3], c1x2b_ff [3], c2b_ff [3], p1b_ff [3];
   logic signed [PROD_W-1:0] m2_ff [3], m2_in [3];
   logic signed [PROD_W-1:0] mg2_ff [3], mg2_in [3];
   logic signed [ACC_W-1:0] c2c_ff [3], p1c_ff [3];
   logic signed [PROD_W-1:0] m3_ff [3], m3_in [3];
   logic signed [ACC_W-1:0] g2_ff [3], g2_in [3];
   logic signed [ACC_W-1:0] p1d_ff [3];
   logic [2:0][COORD_W-1:0] pos_ff, pos_in, der_ff, der_in;

   // The whole back end moves together whenever the output register can load.
   assign adv     = !rsp_valid_ff || rsp_ready;
   assign q_pop   = q_valid && adv;
   assign load_we = q_pop && (q_cmd.op == OP_LOAD) && (32'(q_cmd.slot) < MAX_POINTS);

   // One table copy per read port; loads write all four alike.
   for (genvar k = 0; k < 4; k++) begin : g_table
      cr_eval_ram #(
         .WIDTH(3*COORD_W),
         .DEPTH(MAX_POINTS)
      ) u_table (
         .clock  (clock),
         .wr_en  (load_we),
         .wr_addr(IW'(q_cmd.slot)),
         .wr_data(q_cmd.coord),
         .rd_en  (adv),
         .rd_addr(q_idx[k]),
         .rd_data(rd_data[k])
      );
   end

   always_comb begin
      logic signed [ACC_W-1:0] q0, q1, q2, q3, d;
      logic signed [ACC_W-1:0] h1, g1, h2, h3;
      logic signed [FRAC_W:0] fa, fb, fc;
      fa = $signed({1'b0, f_a_ff});
      fb = $signed({1'b0, f_b_ff});
      fc = $signed({1'b0, f_c_ff});
      for (int a = 0; a < 3; a++) begin
         q0 = ACC_W'($signed(rd_data[0][a*COORD_W +: COORD_W]));
         q1 = ACC_W'($signed(rd_data[1][a*COORD_W +: COORD_W]));
         q2 = ACC_W'($signed(rd_data[2][a*COORD_W +: COORD_W]));
         q3 = ACC_W'($signed(rd_data[3][a*COORD_W +: COORD_W]));
         d  = q1 - q2;
         c0_in[a]   = q3 - q0 + d + d + d;
         c0x3_in[a] = c0_in[a] + c0_in[a] + c0_in[a];
         c1_in[a]   = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
         c1x2_in[a] = c1_in[a] <<< 1;
         c2a_in[a]  = q2 - q0;
         p1a_in[a]  = q1 <<< 1;

         m1_in[a]  = c0_ff[a] * fa;
         mg1_in[a] = c0x3_ff[a] * fa;

         h1        = rnd16(m1_ff[a]) + c1b_ff[a];
         g1        = rnd16(mg1_ff[a]) + c1x2b_ff[a];
         m2_in[a]  = h1 * fb;
         mg2_in[a] = g1 * fb;

         h2        = rnd16(m2_ff[a]) + c2c_ff[a];
         m3_in[a]  = h2 * fc;
         g2_in[a]  = rnd16(mg2_ff[a]) + c2c_ff[a];

         h3         = rnd16(m3_ff[a]) + p1d_ff[a];
         pos_in[a]  = rnd1_sat(h3);
         der_in[a]  = rnd1_sat(g2_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_rd_ff      <= 1'b0;
         v_a_ff       <= 1'b0;
         v_b_ff       <= 1'b0;
         v_c_ff       <= 1'b0;
         v_d_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_rd_ff      <= q_pop && (q_cmd.op == OP_EVAL);
         v_a_ff       <= v_rd_ff;
         v_b_ff       <= v_a_ff;
         v_c_ff       <= v_b_ff;
         v_d_ff       <= v_c_ff;
         rsp_valid_ff <= v_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_rd_ff <= q_cmd.frac;
         f_a_ff  <= f_rd_ff;
         f_b_ff  <= f_a_ff;
         f_c_ff  <= f_b_ff;
         for (int a = 0; a < 3; a++) begin
            c0_ff[a]    <= c0_in[a];
            c0x3_ff[a]  <= c0x3_in[a];
            c1_ff[a]    <= c1_in[a];
            c1x2_ff[a]  <= c1x2_in[a];
            c2a_ff[a]   <= c2a_in[a];
            p1a_ff[a]   <= p1a_in[a];
            m1_ff[a]    <= m1_in[a];
            mg1_ff[a]   <= mg1_in[a];
            c1b_ff[a]   <= c1_ff[a];
            c1x2b_ff[a] <= c1x2_ff[a];
            c2b_ff[a]   <= c2a_ff[a];
            p1b_ff[a]   <= p1a_ff[a];
            m2_ff[a]    <= m2_in[a];
            mg2_ff[a]   <= mg2_in[a];
            c2c_ff[a]   <= c2b_ff[a];
            p1c_ff[a]   <= p1b_ff[a];
            m3_ff[a]    <= m3_in[a];
            g2_ff[a]    <= g2_in[a];
            p1d_ff[a]   <= p1c_ff[a];
         end
         pos_ff <= pos_in;
         der_ff <= der_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos   = pos_ff;
   assign rsp_deriv = der_ff;

   `ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable({v_rd_ff, v_d_ff}), "stall not held")
   `ASSERT_IMPLIES(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(v_d_ff), "orphan result")

endmodule

[src/catmull_rom_closed_curve_eval.sv]
// ----------------------------------------------------------------------------
// catmull_rom_closed_curve_eval
// Closed Catmull-Rom curve evaluator with a loadable control-point table.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the queue has room, load or
// evaluate, and raises rsp_valid for an evaluate once it has passed the queue,
// table read, coefficient, multiply and output registers; rsp_ready held low
// stalls the back end while up to four more items still enter the queue. One
// item per cycle is possible because the point table is kept as four copies of
// one RAM, so all four control points come in one read, and each axis has a
// five-multiplier Horner pipeline. Loads take effect for every later evaluate;
// write the point total only while idle; the block does not enforce this.
module catmull_rom_closed_curve_eval
   import cr_eval_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CNT_W-1:0]          csr_num_points,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [SLOT_W-1:0]         req_point_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic [FRAC_W-1:0]         req_curve_param,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_pos_x,
   output logic signed [COORD_W-1:0] rsp_pos_y,
   output logic signed [COORD_W-1:0] rsp_pos_z,
   output logic signed [COORD_W-1:0] rsp_deriv_x,
   output logic signed [COORD_W-1:0] rsp_deriv_y,
   output logic signed [COORD_W-1:0] rsp_deriv_z
);

   localparam int IW = $clog2(MAX_POINTS);

   logic [CNT_W-1:0]          count_ff, count_in;
   cmd_type                   req_cmd, q_cmd;
   logic                      q_valid, q_pop;
   logic [3:0][IW-1:0]        q_idx;
   logic [2:0][COORD_W-1:0]   pos, deriv;

   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_num_points : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      req_cmd.op       = op_type'(req_op);
      req_cmd.slot     = req_point_index;
      req_cmd.coord[0] = req_coord_x;
      req_cmd.coord[1] = req_coord_y;
      req_cmd.coord[2] = req_coord_z;
      req_cmd.frac     = req_curve_param;
   end

   cr_eval_front u_front (
      .clock      (clock),
      .reset      (reset),
      .num_points (count_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .q_idx      (q_idx)
   );

   cr_eval_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_cmd    (q_cmd),
      .q_idx    (q_idx),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pos  (pos),
      .rsp_deriv(deriv)
   );

   assign rsp_pos_x   = pos[0];
   assign rsp_pos_y   = pos[1];
   assign rsp_pos_z   = pos[2];
   assign rsp_deriv_x = deriv[0];
   assign rsp_deriv_y = deriv[1];
   assign rsp_deriv_z = deriv[2];

endmodule
